// ===== design/utf8_stream_sanitizer_assert.svh =====
// assertion macros used by the sanitizer back end
`ifndef UTF8_STREAM_SANITIZER_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define USAN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequent holds in the cycle after the trigger
`define USAN_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`else
`define USAN_ASSERT(label, prop, msg)
`define USAN_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

// ===== design/usan_pkg.sv =====
// types and constants of the utf-8 stream sanitizer
`timescale 1ns / 1ps

package usan_pkg;

  // replacement character
  localparam logic [15:0] REPL_CP = 16'hFFFD;

  // job queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_beat_t;

  // one input beat's worth of output: one or two code points
  typedef struct packed {
    logic [30:0] cp0;
    logic        has_cp1;
    logic [15:0] cp1;
    logic        eos;
  } job_t;

endpackage

// ===== design/utf8_stream_sanitizer.sv =====
// top level of the utf-8 stream sanitizer
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid_i, in_stall_o, in_data_i | one raw byte, end-of-string flag
//  out     | out_valid_o, out_stall_i, out_data_o | one cleaned byte, run/stream last
//
// the decoder takes one input beat per cycle while the job queue has room
// the encoder sends one output byte per cycle while the output is not stalled; an input
// beat causes 0 to 6 output bytes, three per replacement character
// a beat's first output byte passes through the job queue and the output beat register
// a four-entry job queue lets input run ahead of a stalled output
// reset clears decoder state, queue pointers and the output valid at once
`timescale 1ns / 1ps

module utf8_stream_sanitizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  usan_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output usan_pkg::out_beat_t out_data_o
);

  logic           accept;
  logic           push;
  logic           full;
  logic           q_valid;
  logic           pop;
  usan_pkg::job_t job_in;
  usan_pkg::job_t job_head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  usan_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (job_in)
  );

  usan_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (job_head)
  );

  usan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/usan_front.sv =====
// front end: decodes input bytes and issues encode jobs
`timescale 1ns / 1ps

module usan_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  usan_pkg::in_beat_t in_data_i,
  output logic              push_o,
  output usan_pkg::job_t    job_o
);

  logic [30:0] acc_q, acc_d;
  logic [2:0]  left_q, left_d;
  logic [2:0]  len_q, len_d;
  logic [7:0]  lead_q, lead_d;
  logic        ovl_q, ovl_d;

  logic [7:0]  b;
  logic        eos;
  logic        is_cont;
  logic        sb_bad;
  logic        sb_ascii;
  logic        sb_opens;
  logic        sb_emit;
  logic [15:0] sb_cp;
  logic [2:0]  sb_len;
  logic [30:0] sb_acc;
  logic [15:0] pair;
  logic        pair_ovl;
  logic [30:0] acc_shift;
  logic        ovl_next;
  logic [2:0]  left_dec;
  logic        push;

  assign b   = in_data_i.in_byte;
  assign eos = in_data_i.end_of_string;

  // classify the byte as a fresh start
  always_comb begin
    is_cont  = (b[7:6] == 2'b10);
    sb_bad   = is_cont || (b[7:1] == 7'h7F);
    sb_ascii = !b[7];
    sb_opens = !sb_bad && !sb_ascii;
    sb_emit  = sb_bad || sb_ascii || eos;
    sb_cp    = sb_ascii ? {8'h00, b} : usan_pkg::REPL_CP;
    if (!b[5]) begin
      sb_len = 3'd2;
      sb_acc = {26'd0, b[4:0]};
    end else if (!b[4]) begin
      sb_len = 3'd3;
      sb_acc = {27'd0, b[3:0]};
    end else if (!b[3]) begin
      sb_len = 3'd4;
      sb_acc = {28'd0, b[2:0]};
    end else if (!b[2]) begin
      sb_len = 3'd5;
      sb_acc = {29'd0, b[1:0]};
    end else begin
      sb_len = 3'd6;
      sb_acc = {30'd0, b[0]};
    end
  end

  // continuation step and overlong check on the first two bytes
  always_comb begin
    pair      = {lead_q, b};
    pair_ovl  = ((pair & 16'hFE00) == 16'hC000) || ((pair & 16'hFFE0) == 16'hE080) ||
                ((pair & 16'hFFF0) == 16'hF080) || ((pair & 16'hFFF8) == 16'hF880) ||
                ((pair & 16'hFFFC) == 16'hFC80);
    acc_shift = {acc_q[24:0], b[5:0]};
    ovl_next  = ovl_q || ((left_q == (len_q - 3'd1)) && pair_ovl);
    left_dec  = left_q - 3'd1;
  end

  // sequence state update and job build
  always_comb begin
    acc_d  = acc_q;
    left_d = left_q;
    len_d  = len_q;
    lead_d = lead_q;
    ovl_d  = ovl_q;
    push   = 1'b0;
    job_o  = '0;
    job_o.eos = eos;
    if (left_q != 3'd0) begin
      if (is_cont) begin
        acc_d  = acc_shift;
        ovl_d  = ovl_next;
        left_d = left_dec;
        if (left_dec == 3'd0) begin
          push = 1'b1;
          if (ovl_next || (acc_shift == 31'h0000FFFE) || (acc_shift == 31'h0000FFFF)) begin
            job_o.cp0 = {15'd0, usan_pkg::REPL_CP};
          end else begin
            job_o.cp0 = acc_shift;
          end
        end else if (eos) begin
          push      = 1'b1;
          job_o.cp0 = {15'd0, usan_pkg::REPL_CP};
        end
      end else begin
        // cut short: replace, then restart on this byte
        push          = 1'b1;
        job_o.cp0     = {15'd0, usan_pkg::REPL_CP};
        job_o.has_cp1 = sb_emit;
        job_o.cp1     = sb_cp;
        left_d        = 3'd0;
        if (sb_opens && !eos) begin
          acc_d  = sb_acc;
          left_d = sb_len - 3'd1;
          len_d  = sb_len;
          lead_d = b;
          ovl_d  = 1'b0;
        end
      end
    end else begin
      push      = sb_emit;
      job_o.cp0 = {15'd0, sb_cp};
      if (sb_opens && !eos) begin
        acc_d  = sb_acc;
        left_d = sb_len - 3'd1;
        len_d  = sb_len;
        lead_d = b;
        ovl_d  = 1'b0;
      end
    end
    // sequence closed: clear the rest
    if (eos || (left_d == 3'd0)) begin
      acc_d  = '0;
      left_d = 3'd0;
      len_d  = 3'd0;
      lead_d = 8'h00;
      ovl_d  = 1'b0;
    end
  end

  assign push_o = accept_i && push;

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= 3'd0;
      len_q  <= 3'd0;
      lead_q <= 8'h00;
      ovl_q  <= 1'b0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      left_q <= left_d;
      len_q  <= len_d;
      lead_q <= lead_d;
      ovl_q  <= ovl_d;
    end
  end

endmodule

// ===== design/usan_queue.sv =====
// job queue between decoder and encoder
`timescale 1ns / 1ps

module usan_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  usan_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output usan_pkg::job_t job_o
);

  usan_pkg::job_t mem_q [usan_pkg::Q_DEPTH];
  logic [usan_pkg::Q_PTR_W-1:0] wr_q, wr_d;
  logic [usan_pkg::Q_PTR_W-1:0] rd_q, rd_d;
  logic [usan_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic do_pop;

  assign full_o  = (cnt_q == usan_pkg::Q_CNT_W'(usan_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== design/usan_back.sv =====
// back end: encodes queued code points one byte per cycle while the output is not stalled
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_assert.svh"

module usan_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  usan_pkg::job_t      q_job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output usan_pkg::out_beat_t out_data_o
);

  logic [2:0]  idx_q, idx_d;
  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  usan_pkg::out_beat_t out_q;

  logic [30:0] cur_cp;
  logic [2:0]  cur_len;
  logic [2:0]  pos;
  logic [30:0] sh;
  logic [7:0]  lead_bits;
  logic [7:0]  cur_byte;
  logic        last_cp;
  logic        last_job;
  logic        advance;

  // current code point and its encoded length
  always_comb begin
    cur_cp = phase_q ? {15'd0, q_job_i.cp1} : q_job_i.cp0;
    if (cur_cp < 31'h80) begin
      cur_len = 3'd1;
    end else if (cur_cp < 31'h800) begin
      cur_len = 3'd2;
    end else if (cur_cp < 31'h10000) begin
      cur_len = 3'd3;
    end else if (cur_cp < 31'h200000) begin
      cur_len = 3'd4;
    end else if (cur_cp < 31'h4000000) begin
      cur_len = 3'd5;
    end else begin
      cur_len = 3'd6;
    end
  end

  // select the six-bit group for this byte
  always_comb begin
    pos = cur_len - 3'd1 - idx_q;
    case (pos)
      3'd0:    sh = cur_cp;
      3'd1:    sh = cur_cp >> 6;
      3'd2:    sh = cur_cp >> 12;
      3'd3:    sh = cur_cp >> 18;
      3'd4:    sh = cur_cp >> 24;
      3'd5:    sh = cur_cp >> 30;
      default: sh = cur_cp;
    endcase
    case (cur_len)
      3'd2:    lead_bits = 8'hC0;
      3'd3:    lead_bits = 8'hE0;
      3'd4:    lead_bits = 8'hF0;
      3'd5:    lead_bits = 8'hF8;
      3'd6:    lead_bits = 8'hFC;
      default: lead_bits = 8'h00;
    endcase
    if (cur_len == 3'd1) begin
      cur_byte = cur_cp[7:0];
    end else if (idx_q == 3'd0) begin
      cur_byte = lead_bits | sh[7:0];
    end else begin
      cur_byte = {2'b10, sh[5:0]};
    end
  end

  // byte sequencing
  always_comb begin
    advance  = q_valid_i && (!out_valid_q || !out_stall_i);
    last_cp  = (idx_q == (cur_len - 3'd1));
    last_job = last_cp && (phase_q || !q_job_i.has_cp1);
    pop_o    = advance && last_job;
    idx_d    = idx_q;
    phase_d  = phase_q;
    if (advance) begin
      if (last_job) begin
        idx_d   = 3'd0;
        phase_d = 1'b0;
      end else if (last_cp) begin
        idx_d   = 3'd0;
        phase_d = 1'b1;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte    <= cur_byte;
      out_q.run_last    <= last_job;
      out_q.stream_last <= last_job && q_job_i.eos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `USAN_ASSERT(a_stream_last_ends_run,
    out_valid_o && out_data_o.stream_last |-> out_data_o.run_last,
    "stream_last without run_last")
  `USAN_ASSERT_NEXT(a_job_restart, advance && last_job, (idx_q == 3'd0) && !phase_q,
    "byte counter not rewound after a job")
  `USAN_ASSERT(a_idx_in_range, q_valid_i |-> (idx_q < cur_len),
    "byte index beyond encoded length")

endmodule
